### src/cslc_pkg.sv
package cslc_pkg;

   localparam int RPM_W     = 16;
   localparam int THRESH_W  = 13;
   localparam int TIME_W    = 16;
   localparam int TIMER_W   = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   // Map modes
   localparam logic [1:0] MODE_NORMAL    = 2'd0;
   localparam logic [1:0] MODE_RACE      = 2'd1;
   localparam logic [1:0] MODE_EMERGENCY = 2'd2;
   localparam logic [1:0] MODE_NONE      = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTAKE_NORMAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXHAUST_NORMAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTAKE_RACE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXHAUST_RACE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_TIME   = 3'd4;

   // Register reset values
   localparam logic [THRESH_W-1:0] RST_INTAKE_NORMAL  = 13'd5000;
   localparam logic [THRESH_W-1:0] RST_EXHAUST_NORMAL = 13'd5500;
   localparam logic [THRESH_W-1:0] RST_INTAKE_RACE    = 13'd4500;
   localparam logic [THRESH_W-1:0] RST_EXHAUST_RACE   = 13'd5000;
   localparam logic [TIME_W-1:0]   RST_LOCKOUT_TIME   = 16'd500;

   typedef struct packed {
      logic [1:0]        map_mode;
      logic              engine_running;
      logic [RPM_W-1:0]  rpm;
      logic [TIME_W-1:0] elapsed;
   } req_type;

   typedef struct packed {
      logic intake_high;
      logic exhaust_high;
      logic intake_locked;
      logic exhaust_locked;
   } rsp_type;

   // Per-cam control decoded from the map mode
   typedef struct packed {
      logic follow;      // track rpm against threshold
      logic force_high;  // request high lobe unconditionally
   } cam_ctl_type;

   // Per-cam status after the tick
   typedef struct packed {
      logic on;
      logic lock;
   } cam_status_type;

endpackage

### src/cslc_cam.sv
module cslc_cam (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  cslc_pkg::cam_ctl_type             ctl,
   input  logic [cslc_pkg::RPM_W-1:0]        rpm,
   input  logic [cslc_pkg::THRESH_W-1:0]     threshold,
   input  logic [cslc_pkg::TIME_W-1:0]       elapsed,
   input  logic [cslc_pkg::TIME_W-1:0]       lockout_time,
   output cslc_pkg::cam_status_type          status
);
   import cslc_pkg::*;

   logic               on_ff, on_in;
   logic               lock_ff, lock_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;

   logic               at_speed;
   logic               attempt;
   logic               want_high;
   logic               sw_on, sw_lock;
   logic [TIMER_W:0]   sum;

   always_comb begin
      at_speed  = rpm >= {{(RPM_W-THRESH_W){1'b0}}, threshold};
      want_high = ctl.force_high | at_speed;
      attempt   = ctl.force_high | (ctl.follow & (at_speed != on_ff));

      // switch request, ignored while locked out
      if (attempt && !lock_ff) begin
         sw_on   = want_high;
         sw_lock = 1'b1;
      end else begin
         sw_on   = on_ff;
         sw_lock = lock_ff;
      end

      // lockout timer, saturating add
      sum      = {1'b0, timer_ff} + {{(TIMER_W+1-TIME_W){1'b0}}, elapsed};
      on_in    = sw_on;
      lock_in  = sw_lock;
      timer_in = timer_ff;
      if (sw_lock) begin
         if (timer_ff >= {{(TIMER_W-TIME_W){1'b0}}, lockout_time}) begin
            lock_in  = 1'b0;
            timer_in = '0;
         end else if (sum[TIMER_W]) begin
            timer_in = TIMER_MAX;
         end else begin
            timer_in = sum[TIMER_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff    <= 1'b0;
         lock_ff  <= 1'b1;
         timer_ff <= '0;
      end else if (advance) begin
         on_ff    <= on_in;
         lock_ff  <= lock_in;
         timer_ff <= timer_in;
      end
   end

   assign status.on   = on_in;
   assign status.lock = lock_in;

endmodule

### src/cam_switch_lockout_controller_unit.sv
// A request passes through the input register, then the result register; the input
// register advances only while the result register is free or being drained.
// Throughput: one tick per cycle while rsp_stall is low; the cam update is a compare
// and a 17-bit saturating add between the input register and the result register.
// Reset (synchronous, active high): both cams on the low lobe and locked, timers at zero,
// thresholds and lockout time at their defaults, both pipeline stages empty.
module cam_switch_lockout_controller_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  cslc_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output cslc_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [cslc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cslc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cslc_pkg::*;

   // Configuration registers
   logic [THRESH_W-1:0] intake_normal_ff, exhaust_normal_ff;
   logic [THRESH_W-1:0] intake_race_ff, exhaust_race_ff;
   logic [TIME_W-1:0]   lockout_time_ff;

   // Input stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // Result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic           advance;
   logic           req_take;
   cam_ctl_type    intake_ctl, exhaust_ctl;
   logic [THRESH_W-1:0] intake_thr, exhaust_thr;
   cam_status_type intake_status, exhaust_status;

   // Register writes: drop unknown indexes, keep only the register's own bits
   always_ff @(posedge clock) begin
      if (reset) begin
         intake_normal_ff  <= RST_INTAKE_NORMAL;
         exhaust_normal_ff <= RST_EXHAUST_NORMAL;
         intake_race_ff    <= RST_INTAKE_RACE;
         exhaust_race_ff   <= RST_EXHAUST_RACE;
         lockout_time_ff   <= RST_LOCKOUT_TIME;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTAKE_NORMAL:  intake_normal_ff  <= csr_wdata[THRESH_W-1:0];
            CSR_EXHAUST_NORMAL: exhaust_normal_ff <= csr_wdata[THRESH_W-1:0];
            CSR_INTAKE_RACE:    intake_race_ff    <= csr_wdata[THRESH_W-1:0];
            CSR_EXHAUST_RACE:   exhaust_race_ff   <= csr_wdata[THRESH_W-1:0];
            CSR_LOCKOUT_TIME:   lockout_time_ff   <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the input stage whenever the result register is free or being drained;
   // the cam state updates on exactly that edge, so ticks apply in order.
   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   // Mode decode: follow rpm only with the engine running, force high in emergency,
   // no switch attempt in mode none.
   always_comb begin
      intake_ctl  = '0;
      exhaust_ctl = '0;
      intake_thr  = intake_normal_ff;
      exhaust_thr = exhaust_normal_ff;
      case (s1_data_ff.map_mode)
         MODE_NORMAL: begin
            intake_ctl.follow  = s1_data_ff.engine_running;
            exhaust_ctl.follow = s1_data_ff.engine_running;
         end
         MODE_RACE: begin
            intake_ctl.follow  = s1_data_ff.engine_running;
            exhaust_ctl.follow = s1_data_ff.engine_running;
            intake_thr         = intake_race_ff;
            exhaust_thr        = exhaust_race_ff;
         end
         MODE_EMERGENCY: begin
            intake_ctl.force_high  = 1'b1;
            exhaust_ctl.force_high = 1'b1;
         end
         MODE_NONE: ;
         default: ;
      endcase
   end

   cslc_cam u_intake (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctl          (intake_ctl),
      .rpm          (s1_data_ff.rpm),
      .threshold    (intake_thr),
      .elapsed      (s1_data_ff.elapsed),
      .lockout_time (lockout_time_ff),
      .status       (intake_status)
   );

   cslc_cam u_exhaust (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .ctl          (exhaust_ctl),
      .rpm          (s1_data_ff.rpm),
      .threshold    (exhaust_thr),
      .elapsed      (s1_data_ff.elapsed),
      .lockout_time (lockout_time_ff),
      .status       (exhaust_status)
   );

   always_comb begin
      // input stage: fill on a transfer, empty once advanced
      s1_valid_in = req_take | (s1_valid_ff & ~advance);

      // result stage: load on advance, hold while stalled, drop once taken
      rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);

      rsp_data_in.intake_high    = intake_status.on;
      rsp_data_in.exhaust_high   = exhaust_status.on;
      rsp_data_in.intake_locked  = intake_status.lock;
      rsp_data_in.exhaust_locked = exhaust_status.lock;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/cslc_checker.sv
module cslc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input cslc_pkg::rsp_type              rsp_data
);
   import cslc_pkg::*;

   // Both stages empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Input only backs up when the result side is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while result side can drain");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind cam_switch_lockout_controller_unit cslc_checker u_cslc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
